@@ rtl/goga_pkg.sv @@
// ----------------------------------------------------------------------------
// goga_pkg
// Types, codes and constants shared by the gene order global aligner.
// ----------------------------------------------------------------------------
package goga_pkg;

  // Default sizing of the tables and of the score arithmetic.
  localparam int MAX_LEN_DEF     = 64;
  localparam int SCORE_WIDTH_DEF = 20;

  // Configuration port sizing.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_GAP_SCORE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH_SCORE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AP_SCORE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOM_SCORE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAPS       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_X          = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_Y          = 3'd6;

  // Command codes of an input word.
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_ALIGN = 2'd2;

  // Input word.
  typedef struct packed {
    logic [1:0] command;
    logic [5:0] hit_x;
    logic [5:0] hit_y;
    logic       hit_is_ap;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [5:0]         pos_x;
    logic [5:0]         pos_y;
    logic [6:0]         gaps_x_count;
    logic [6:0]         gaps_x_at;
    logic [6:0]         gaps_y_count;
    logic [6:0]         gaps_y_at;
    logic               too_many_gaps;
    logic               no_hits;
    logic signed [19:0] final_score;
    logic               last;
  } out_word_t;

  // Configuration register contents.
  typedef struct packed {
    logic signed [7:0] gap_score;
    logic signed [7:0] mismatch_score;
    logic signed [7:0] ap_score;
    logic signed [7:0] hom_score;
    logic [6:0]        max_gaps;
    logic [6:0]        len_x;
    logic [6:0]        len_y;
  } cfg_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CLR_STEP,
    OP_LD_RD,
    OP_LD_WR,
    OP_AL_START,
    OP_INIT_STEP,
    OP_COL_START,
    OP_CELL_RD,
    OP_CELL_ADD,
    OP_CELL_WR,
    OP_FIN_RD,
    OP_FIN_CAP,
    OP_TB_RD0,
    OP_TB_RD1,
    OP_TB_RD2,
    OP_TB_RD3,
    OP_TB_DEC,
    OP_EM_START,
    OP_EM_RD,
    OP_EM_OUT,
    OP_EM_EMPTY
  } op_t;

  // Controller to datapath.
  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] command;
    logic       clr_done;
    logic       ld_ok;
    logic       row_done;
    logic       col_last;
    logic       ly_zero;
    logic       tb_end;
    logic       n_zero;
    logic       em_last;
    logic       out_free;
  } dp_status_t;

endpackage

@@ rtl/gene_order_global_aligner_unit.sv @@
// ----------------------------------------------------------------------------
// gene_order_global_aligner_unit
// Global alignment of gene order profiles over a table of homolog hits, with
// traceback and gap-run reporting for the hits on the best path.
//
//   channel | direction | handshake          | payload
//   in_     | into      | in_valid/in_stall  | in_word   (goga_pkg::in_word_t)
//   out_    | out of    | out_valid/out_stall| out_word  (goga_pkg::out_word_t)
//   cfg_    | into      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Clear writes every hit table entry, one entry a cycle; a load writes its
// entry when it is empty or the new score is better. An align fills the
// matrix over one port in three steps a cell, walks back with four reads and
// a decision a step and emits the hits from the path store. After reset the
// same clearing pass runs before a word is taken. A stalled result holds the
// emission; the next word may be taken while the last result still waits.
// ----------------------------------------------------------------------------
module gene_order_global_aligner_unit #(
  parameter int MAX_LEN     = goga_pkg::MAX_LEN_DEF,
  parameter int SCORE_WIDTH = goga_pkg::SCORE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  goga_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output goga_pkg::out_word_t                 out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [goga_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [goga_pkg::CFG_DATA_W-1:0]     cfg_data
);

  goga_pkg::cfg_t       cfg_r;
  goga_pkg::dp_cmd_t    cmd;
  goga_pkg::dp_status_t sts;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gap_score      <= -8'sd1;
      cfg_r.mismatch_score <= 8'sd0;
      cfg_r.ap_score       <= 8'sd10;
      cfg_r.hom_score      <= 8'sd5;
      cfg_r.max_gaps       <= 7'd30;
      cfg_r.len_x          <= 7'd64;
      cfg_r.len_y          <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        goga_pkg::REG_GAP_SCORE:      cfg_r.gap_score      <= cfg_data;
        goga_pkg::REG_MISMATCH_SCORE: cfg_r.mismatch_score <= cfg_data;
        goga_pkg::REG_AP_SCORE:       cfg_r.ap_score       <= cfg_data;
        goga_pkg::REG_HOM_SCORE:      cfg_r.hom_score      <= cfg_data;
        goga_pkg::REG_MAX_GAPS:       cfg_r.max_gaps       <= cfg_data[6:0];
        goga_pkg::REG_LEN_X:          cfg_r.len_x          <= cfg_data[6:0];
        goga_pkg::REG_LEN_Y:          cfg_r.len_y          <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  goga_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  goga_dp #(
    .MAX_LEN     (MAX_LEN),
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

@@ rtl/goga_ctrl.sv @@
// ----------------------------------------------------------------------------
// goga_ctrl
// Sequencer of the aligner: walks the clear, load, fill, traceback and
// emission phases and issues at most one datapath operation per cycle.
// ----------------------------------------------------------------------------
module goga_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  goga_pkg::dp_status_t sts,
  output goga_pkg::dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LD_RD, S_LD_WR, S_AL_START, S_INIT, S_COL, S_C_RD,
    S_C_ADD, S_C_WR, S_COL_END, S_FIN_RD, S_FIN_CAP, S_T_RD0, S_T_RD1,
    S_T_RD2, S_T_RD3, S_T_DEC, S_T_CHK, S_EM_START, S_EM_RD, S_EM_OUT,
    S_EM_EMPTY
  } state_t;

  state_t state_r, state_nxt;

  // Words are taken only while no operation is in progress.
  assign in_stall = (state_r != S_IDLE);

  // Next state and the operation of the current state.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = goga_pkg::OP_NONE;
    case (state_r)
      S_CLR: begin
        cmd.op = goga_pkg::OP_CLR_STEP;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = goga_pkg::OP_ACCEPT;
          case (sts.command)
            goga_pkg::CMD_CLEAR: state_nxt = S_CLR;
            goga_pkg::CMD_LOAD:  state_nxt = S_LD_RD;
            goga_pkg::CMD_ALIGN: state_nxt = S_AL_START;
            default:             state_nxt = S_IDLE;
          endcase
        end
      end
      S_LD_RD: begin
        if (sts.ld_ok) begin
          cmd.op    = goga_pkg::OP_LD_RD;
          state_nxt = S_LD_WR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LD_WR: begin
        cmd.op    = goga_pkg::OP_LD_WR;
        state_nxt = S_IDLE;
      end
      S_AL_START: begin
        cmd.op    = goga_pkg::OP_AL_START;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.op = goga_pkg::OP_INIT_STEP;
        if (sts.row_done) state_nxt = sts.col_last ? S_FIN_RD : S_COL;
      end
      S_COL: begin
        cmd.op    = goga_pkg::OP_COL_START;
        state_nxt = sts.ly_zero ? S_COL_END : S_C_RD;
      end
      S_C_RD: begin
        cmd.op    = goga_pkg::OP_CELL_RD;
        state_nxt = S_C_ADD;
      end
      S_C_ADD: begin
        cmd.op    = goga_pkg::OP_CELL_ADD;
        state_nxt = S_C_WR;
      end
      S_C_WR: begin
        cmd.op    = goga_pkg::OP_CELL_WR;
        state_nxt = sts.row_done ? S_COL_END : S_C_RD;
      end
      S_COL_END: begin
        state_nxt = sts.col_last ? S_FIN_RD : S_COL;
      end
      S_FIN_RD: begin
        cmd.op    = goga_pkg::OP_FIN_RD;
        state_nxt = S_FIN_CAP;
      end
      S_FIN_CAP: begin
        cmd.op    = goga_pkg::OP_FIN_CAP;
        state_nxt = sts.tb_end ? S_EM_START : S_T_RD0;
      end
      S_T_RD0: begin
        cmd.op    = goga_pkg::OP_TB_RD0;
        state_nxt = S_T_RD1;
      end
      S_T_RD1: begin
        cmd.op    = goga_pkg::OP_TB_RD1;
        state_nxt = S_T_RD2;
      end
      S_T_RD2: begin
        cmd.op    = goga_pkg::OP_TB_RD2;
        state_nxt = S_T_RD3;
      end
      S_T_RD3: begin
        cmd.op    = goga_pkg::OP_TB_RD3;
        state_nxt = S_T_DEC;
      end
      S_T_DEC: begin
        cmd.op    = goga_pkg::OP_TB_DEC;
        state_nxt = S_T_CHK;
      end
      S_T_CHK: begin
        state_nxt = sts.tb_end ? S_EM_START : S_T_RD0;
      end
      S_EM_START: begin
        cmd.op    = goga_pkg::OP_EM_START;
        state_nxt = sts.n_zero ? S_EM_EMPTY : S_EM_RD;
      end
      S_EM_RD: begin
        cmd.op    = goga_pkg::OP_EM_RD;
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (sts.out_free) begin
          cmd.op    = goga_pkg::OP_EM_OUT;
          state_nxt = sts.em_last ? S_IDLE : S_EM_RD;
        end
      end
      S_EM_EMPTY: begin
        if (sts.out_free) begin
          cmd.op    = goga_pkg::OP_EM_EMPTY;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register; reset starts the clearing pass of the hit table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/goga_dp.sv @@
// ----------------------------------------------------------------------------
// goga_dp
// Datapath of the aligner: hit table, score matrix and path memories, the
// cell counters, the saturating score arithmetic and the result register.
// ----------------------------------------------------------------------------
module goga_dp #(
  parameter int MAX_LEN     = goga_pkg::MAX_LEN_DEF,
  parameter int SCORE_WIDTH = goga_pkg::SCORE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  goga_pkg::cfg_t       cfg,
  input  goga_pkg::in_word_t   in_word,
  input  goga_pkg::dp_cmd_t    cmd,
  output goga_pkg::dp_status_t sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output goga_pkg::out_word_t  out_word
);

  localparam int SW   = SCORE_WIDTH;
  localparam int MDIM = MAX_LEN + 1;
  localparam int CW   = $clog2(MAX_LEN + 1);
  localparam int HD   = MAX_LEN * MAX_LEN;
  localparam int HW   = $clog2(HD);
  localparam int MD   = MDIM * MDIM;
  localparam int MW   = $clog2(MD);
  localparam int PW   = $clog2(MAX_LEN);
  localparam int NW   = $clog2(MAX_LEN + 1);

  // Saturating add of an 8 bit score to a matrix value.
  function automatic logic signed [SW-1:0] sadd(input logic signed [SW-1:0] a,
                                                input logic signed [7:0]    b);
    logic signed [SW:0] s;
    s = {a[SW-1], a} + {{(SW - 7){b[7]}}, b};
    if (s[SW] != s[SW-1]) begin
      sadd = s[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
    end else begin
      sadd = s[SW-1:0];
    end
  endfunction

  // Clamp a 10 bit gap value to a 7 bit field.
  function automatic logic [6:0] sat7(input logic [9:0] v);
    sat7 = (v > 10'd127) ? 7'd127 : v[6:0];
  endfunction

  // Low six bits of a coordinate, as kept in the path store.
  function automatic logic [5:0] low6(input logic [CW-1:0] v);
    logic [31:0] t;
    t    = 32'(v);
    low6 = t[5:0];
  endfunction

  // Memories.
  logic [8:0]           hmem [HD];
  logic signed [SW-1:0] mmem [MD];
  logic [11:0]          pmem [MAX_LEN];

  logic [8:0]           hrd_r;
  logic signed [SW-1:0] mrd_r;
  logic [11:0]          prd_r;

  // Control and working registers.
  goga_pkg::in_word_t   item_r;
  logic [HW-1:0]        cc_r;
  logic [CW-1:0]        x_r, y_r, lx_r, ly_r;
  logic signed [SW-1:0] bnd_r, up_r, diag_r, left_r, c_r, d_r, u_r, l_r;
  logic signed [19:0]   fin_r;
  logic [NW-1:0]        n_r;
  logic [PW-1:0]        e_r;
  logic [7:0]           gx_r, gy_r;
  logic                 out_valid_r;
  goga_pkg::out_word_t  out_r;

  // Port selections.
  logic                 h_re, h_we, m_re, m_we, p_we;
  logic [CW-1:0]        hx_sel, hy_sel, mx_sel, my_sel;
  logic [HW-1:0]        h_addr, h_waddr;
  logic [8:0]           h_wdata;
  logic [MW-1:0]        m_addr;
  logic signed [SW-1:0] m_wdata;

  // Derived values.
  logic signed [7:0]    hs, ld_s;
  logic signed [SW-1:0] bnd_nxt, best, dd, ll, uu;
  logic signed [19:0]   fin_sat;
  logic [CW-1:0]        lx_eff, ly_eff, xm1, ym1;
  logic                 out_free, ld_better;

  // Gap arithmetic of one result.
  logic [9:0]           px, py, ax, ay, ax2, ng1, ng2, gxs, gys;
  logic [7:0]           gx_nxt, gy_nxt;
  logic                 xrun, yrun, fail1, fail2;
  goga_pkg::out_word_t  res;
  goga_pkg::out_word_t  empty_w;

  assign xm1 = x_r - CW'(1);
  assign ym1 = y_r - CW'(1);

  // Effective lengths: a length above the table size acts as the table size.
  assign lx_eff = (int'(cfg.len_x) > MAX_LEN) ? CW'(MAX_LEN) : CW'(cfg.len_x);
  assign ly_eff = (int'(cfg.len_y) > MAX_LEN) ? CW'(MAX_LEN) : CW'(cfg.len_y);

  // Score of the current cell: hit score where valid, else the mismatch score.
  assign hs = hrd_r[8] ? $signed(hrd_r[7:0]) : cfg.mismatch_score;

  assign bnd_nxt = sadd(bnd_r, cfg.gap_score);
  assign ld_s    = item_r.hit_is_ap ? cfg.ap_score : cfg.hom_score;
  assign ld_better = !hrd_r[8] || (ld_s > $signed(hrd_r[7:0]));

  // Best of diagonal, up and left, in that order of preference.
  always_comb begin
    best = d_r;
    if (u_r > best) best = u_r;
    if (l_r > best) best = l_r;
  end

  // Traceback candidates.
  assign dd = sadd(diag_r, hs);
  assign ll = sadd(left_r, cfg.gap_score);
  assign uu = sadd(mrd_r, cfg.gap_score);

  // Final score clamped to the 20 bit result field.
  if (SW > 20) begin : g_fin_clamp
    localparam logic signed [SW-1:0] F_HI = SW'(524287);
    localparam logic signed [SW-1:0] F_LO = -F_HI - SW'(1);
    assign fin_sat = (mrd_r > F_HI) ? 20'sd524287 :
                     (mrd_r < F_LO) ? -20'sd524288 : 20'(mrd_r);
  end else begin : g_fin_ext
    assign fin_sat = 20'(mrd_r);
  end

  // Address and write selection of the three memories.
  always_comb begin
    h_re    = 1'b0;
    h_we    = 1'b0;
    m_re    = 1'b0;
    m_we    = 1'b0;
    p_we    = 1'b0;
    hx_sel  = xm1;
    hy_sel  = ym1;
    mx_sel  = x_r;
    my_sel  = y_r;
    h_waddr = cc_r;
    h_wdata = 9'd0;
    m_wdata = best;
    case (cmd.op)
      goga_pkg::OP_CLR_STEP: begin
        h_we = 1'b1;
      end
      goga_pkg::OP_LD_RD: begin
        h_re = 1'b1;
      end
      goga_pkg::OP_LD_WR: begin
        h_we    = ld_better;
        h_wdata = {1'b1, ld_s};
      end
      goga_pkg::OP_INIT_STEP: begin
        m_we    = 1'b1;
        mx_sel  = '0;
        m_wdata = bnd_r;
      end
      goga_pkg::OP_COL_START: begin
        m_we    = 1'b1;
        mx_sel  = x_r + CW'(1);
        my_sel  = '0;
        m_wdata = bnd_nxt;
      end
      goga_pkg::OP_CELL_RD: begin
        h_re   = 1'b1;
        m_re   = 1'b1;
        mx_sel = xm1;
      end
      goga_pkg::OP_CELL_WR: begin
        m_we = 1'b1;
      end
      goga_pkg::OP_FIN_RD: begin
        m_re   = 1'b1;
        mx_sel = lx_r;
        my_sel = ly_r;
      end
      goga_pkg::OP_TB_RD0: begin
        h_re = 1'b1;
        m_re = 1'b1;
      end
      goga_pkg::OP_TB_RD1: begin
        m_re   = 1'b1;
        mx_sel = xm1;
        my_sel = ym1;
      end
      goga_pkg::OP_TB_RD2: begin
        m_re   = 1'b1;
        mx_sel = xm1;
      end
      goga_pkg::OP_TB_RD3: begin
        m_re   = 1'b1;
        my_sel = ym1;
      end
      goga_pkg::OP_TB_DEC: begin
        p_we = hrd_r[8] && (int'(n_r) < MAX_LEN);
      end
      default: begin
      end
    endcase
    if (cmd.op == goga_pkg::OP_LD_RD || cmd.op == goga_pkg::OP_LD_WR) begin
      h_addr = HW'(item_r.hit_y) * HW'(MAX_LEN) + HW'(item_r.hit_x);
    end else begin
      h_addr = HW'(hy_sel) * HW'(MAX_LEN) + HW'(hx_sel);
    end
    if (cmd.op != goga_pkg::OP_CLR_STEP) h_waddr = h_addr;
    m_addr = MW'(mx_sel) * MW'(MDIM) + MW'(my_sel);
  end

  // Hit table: valid bit and score in one word.
  always_ff @(posedge clk) begin
    if (h_we) hmem[h_waddr] <= h_wdata;
    if (h_re) hrd_r <= hmem[h_addr];
  end

  // Score matrix.
  always_ff @(posedge clk) begin
    if (m_we) mmem[m_addr] <= m_wdata;
    if (m_re) mrd_r <= mmem[m_addr];
  end

  // Path store, filled during traceback and read back in reverse.
  always_ff @(posedge clk) begin
    if (p_we) pmem[n_r[PW-1:0]] <= {low6(ym1), low6(xm1)};
    if (cmd.op == goga_pkg::OP_EM_RD) prd_r <= pmem[e_r];
  end

  // Gap runs of the hit being emitted.
  always_comb begin
    px    = {4'd0, prd_r[5:0]};
    py    = {4'd0, prd_r[11:6]};
    ax    = px + {2'd0, gx_r};
    ay    = py + {2'd0, gy_r};
    xrun  = ax < ay;
    ng1   = ay - ax;
    fail1 = xrun && (ng1 > {3'd0, cfg.max_gaps});
    gxs   = {2'd0, gx_r} + ng1;
    gx_nxt = gx_r;
    if (xrun && !fail1) gx_nxt = (gxs > 10'd255) ? 8'd255 : gxs[7:0];
    ax2   = px + {2'd0, gx_nxt};
    yrun  = !fail1 && (ax2 > ay);
    ng2   = ax2 - ay;
    fail2 = yrun && (ng2 > {3'd0, cfg.max_gaps});
    gys   = {2'd0, gy_r} + ng2;
    gy_nxt = gy_r;
    if (yrun && !fail2) gy_nxt = (gys > 10'd255) ? 8'd255 : gys[7:0];

    res               = '0;
    res.pos_x         = prd_r[5:0];
    res.pos_y         = prd_r[11:6];
    res.gaps_x_count  = xrun ? sat7(ng1) : 7'd0;
    res.gaps_x_at     = xrun ? sat7(ax) : 7'd0;
    res.gaps_y_count  = yrun ? sat7(ng2) : 7'd0;
    res.gaps_y_at     = yrun ? sat7(ay) : 7'd0;
    res.too_many_gaps = fail1 || fail2;
    res.final_score   = fin_r;
    res.last          = fail1 || fail2 || (e_r == '0);
  end

  // The single word of a path without hits.
  always_comb begin
    empty_w             = '0;
    empty_w.no_hits     = 1'b1;
    empty_w.last        = 1'b1;
    empty_w.final_score = fin_r;
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= '0;
    end else if (cmd.op == goga_pkg::OP_CLR_STEP) begin
      cc_r <= (int'(cc_r) == HD - 1) ? '0 : cc_r + HW'(1);
    end
    case (cmd.op)
      goga_pkg::OP_ACCEPT: begin
        item_r <= in_word;
      end
      goga_pkg::OP_AL_START: begin
        lx_r  <= lx_eff;
        ly_r  <= ly_eff;
        x_r   <= '0;
        y_r   <= '0;
        bnd_r <= '0;
      end
      goga_pkg::OP_INIT_STEP: begin
        if (y_r == ly_r) begin
          bnd_r <= '0;
        end else begin
          bnd_r <= bnd_nxt;
          y_r   <= y_r + CW'(1);
        end
      end
      goga_pkg::OP_COL_START: begin
        diag_r <= bnd_r;
        bnd_r  <= bnd_nxt;
        up_r   <= bnd_nxt;
        x_r    <= x_r + CW'(1);
        y_r    <= CW'(1);
      end
      goga_pkg::OP_CELL_ADD: begin
        d_r    <= sadd(diag_r, hs);
        u_r    <= sadd(up_r, cfg.gap_score);
        l_r    <= sadd(mrd_r, cfg.gap_score);
        diag_r <= mrd_r;
      end
      goga_pkg::OP_CELL_WR: begin
        up_r <= best;
        if (y_r != ly_r) y_r <= y_r + CW'(1);
      end
      goga_pkg::OP_FIN_RD: begin
        x_r <= lx_r;
        y_r <= ly_r;
        n_r <= '0;
      end
      goga_pkg::OP_FIN_CAP: begin
        fin_r <= fin_sat;
      end
      // Each read lands in the read register for the next operation: M(x,y) first, then M(x-1,y-1), then
      // M(x-1,y); M(x,y-1) is still in the read register at the decision.
      goga_pkg::OP_TB_RD1: begin
        c_r <= mrd_r;
      end
      goga_pkg::OP_TB_RD2: begin
        diag_r <= mrd_r;
      end
      goga_pkg::OP_TB_RD3: begin
        left_r <= mrd_r;
      end
      goga_pkg::OP_TB_DEC: begin
        if (p_we) n_r <= n_r + NW'(1);
        if (c_r == dd) begin
          x_r <= xm1;
          y_r <= ym1;
        end else if (c_r == ll) begin
          x_r <= xm1;
        end else if (c_r == uu) begin
          y_r <= ym1;
        end else begin
          x_r <= xm1;
          y_r <= ym1;
        end
      end
      goga_pkg::OP_EM_START: begin
        gx_r <= '0;
        gy_r <= '0;
        e_r  <= PW'(n_r - NW'(1));
      end
      goga_pkg::OP_EM_OUT: begin
        gx_r <= gx_nxt;
        gy_r <= gy_nxt;
        e_r  <= e_r - PW'(1);
      end
      default: begin
      end
    endcase
  end

  // Result register; a word waits here until the far side takes it.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == goga_pkg::OP_EM_OUT || cmd.op == goga_pkg::OP_EM_EMPTY) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.op == goga_pkg::OP_EM_OUT) begin
      out_r <= res;
    end else if (cmd.op == goga_pkg::OP_EM_EMPTY) begin
      out_r <= empty_w;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // Status to the controller.
  always_comb begin
    sts          = '0;
    sts.command  = in_word.command;
    sts.clr_done = (int'(cc_r) == HD - 1);
    sts.ld_ok    = (int'(item_r.hit_x) < MAX_LEN) && (int'(item_r.hit_y) < MAX_LEN);
    sts.row_done = (y_r == ly_r);
    sts.col_last = (x_r == lx_r);
    sts.ly_zero  = (ly_r == '0);
    sts.tb_end   = (x_r == '0) || (y_r == '0);
    sts.n_zero   = (n_r == '0);
    sts.em_last  = res.last;
    sts.out_free = out_free;
  end

endmodule

@@ verif/gene_order_global_aligner_unit_tb.sv @@
// ----------------------------------------------------------------------------
// gene_order_global_aligner_unit_tb
// Self-checking bench for the gene order global aligner. A scoreboard class
// keeps its own hit table and registers, applies every accepted word and
// predicts the path results of each align. Words are offered and results
// taken with random idle gaps; the register settings change between phases.
// ----------------------------------------------------------------------------
module gene_order_global_aligner_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_LEN  = 64;
  localparam int CYCLE_CAP  = 1500000;
  localparam int SETTLE_CYC = 5000;

  // Command code that the block ignores.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Scoreboard: predicts path results and compares the block's words.
  class align_scoreboard;
    logic signed [7:0] gap_sc, mism_sc, ap_sc, hom_sc;
    logic [6:0]        max_gap_run, len_x_r, len_y_r;
    logic signed [7:0] hit_sc [TABLE_LEN*TABLE_LEN];
    bit                hit_ok [TABLE_LEN*TABLE_LEN];
    longint            mat [TABLE_LEN+1][TABLE_LEN+1];
    goga_pkg::out_word_t pending [$];
    int                errors, checked, aligns;

    function new();
      gap_sc = -8'sd1; mism_sc = 8'sd0; ap_sc = 8'sd10; hom_sc = 8'sd5;
      max_gap_run = 7'd30; len_x_r = 7'd64; len_y_r = 7'd64;
      foreach (hit_ok[i]) hit_ok[i] = 1'b0;
      errors = 0; checked = 0; aligns = 0;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    function void set_reg(logic [goga_pkg::CFG_IDX_W-1:0] idx,
                          logic [goga_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        goga_pkg::REG_GAP_SCORE:      gap_sc = d;
        goga_pkg::REG_MISMATCH_SCORE: mism_sc = d;
        goga_pkg::REG_AP_SCORE:       ap_sc = d;
        goga_pkg::REG_HOM_SCORE:      hom_sc = d;
        goga_pkg::REG_MAX_GAPS:       max_gap_run = d[6:0];
        goga_pkg::REG_LEN_X:          len_x_r = d[6:0];
        goga_pkg::REG_LEN_Y:          len_y_r = d[6:0];
        default: ;
      endcase
    endfunction

    function longint sat_sc(longint v);
      return v > 524287 ? 524287 : (v < -524288 ? -524288 : v);
    endfunction

    function int clip_len(logic [6:0] r);
      return r > TABLE_LEN ? TABLE_LEN : int'(r);
    endfunction

    function logic [6:0] sat7(longint v);
      return v > 127 ? 7'd127 : (v < 0 ? 7'd0 : v[6:0]);
    endfunction

    function longint cell_sc(int x, int y, output bit is_hit);
      is_hit = hit_ok[y*TABLE_LEN+x];
      return is_hit ? longint'(hit_sc[y*TABLE_LEN+x]) : longint'(mism_sc);
    endfunction

    // Fill, traceback and gap-run emission of one align word.
    function void predict_align();
      int lx, ly, x, y, k, px, py;
      longint g, d, u, l, b, s, c, fin, gx, gy, ng;
      bit h, fail;
      int path_x [$], path_y [$];
      goga_pkg::out_word_t ow;
      lx = clip_len(len_x_r); ly = clip_len(len_y_r); g = gap_sc;
      for (x = 0; x <= lx; x++) mat[x][0] = sat_sc(x * g);
      for (y = 0; y <= ly; y++) mat[0][y] = sat_sc(y * g);
      for (x = 1; x <= lx; x++)
        for (y = 1; y <= ly; y++) begin
          d = sat_sc(mat[x-1][y-1] + cell_sc(x-1, y-1, h));
          u = sat_sc(mat[x][y-1] + g);
          l = sat_sc(mat[x-1][y] + g);
          b = d;
          if (u > b) b = u;
          if (l > b) b = l;
          mat[x][y] = b;
        end
      fin = mat[lx][ly];
      // Walk back: diagonal first, then left, then up.
      x = lx; y = ly;
      while (x > 0 && y > 0) begin
        s = cell_sc(x-1, y-1, h);
        c = mat[x][y];
        if (h && path_x.size() < TABLE_LEN) begin
          path_x = {path_x, x-1}; path_y = {path_y, y-1};
        end
        if (c == sat_sc(mat[x-1][y-1] + s)) begin x--; y--; end
        else if (c == sat_sc(mat[x-1][y] + g)) x--;
        else if (c == sat_sc(mat[x][y-1] + g)) y--;
        else begin x--; y--; end
      end
      if (path_x.size() == 0) begin
        ow = '0;
        ow.no_hits = 1'b1;
        ow.final_score = fin[19:0];
        ow.last = 1'b1;
        pending = {pending, ow};
        return;
      end
      // Emit hits in forward order with the gap runs that line them up.
      gx = 0; gy = 0;
      for (k = path_x.size() - 1; k >= 0; k--) begin
        px = path_x[k]; py = path_y[k];
        fail = 1'b0;
        ow = '0;
        ow.pos_x = px[5:0];
        ow.pos_y = py[5:0];
        if (px + gx < py + gy) begin
          ng = py + gy - px - gx;
          ow.gaps_x_count = sat7(ng);
          ow.gaps_x_at = sat7(px + gx);
          if (ng > max_gap_run) fail = 1'b1;
          else gx = (gx + ng > 255) ? 255 : gx + ng;
        end
        if (!fail && px + gx > py + gy) begin
          ng = px + gx - py - gy;
          ow.gaps_y_count = sat7(ng);
          ow.gaps_y_at = sat7(py + gy);
          if (ng > max_gap_run) fail = 1'b1;
          else gy = (gy + ng > 255) ? 255 : gy + ng;
        end
        ow.too_many_gaps = fail;
        ow.final_score = fin[19:0];
        ow.last = fail || k == 0;
        pending = {pending, ow};
        if (fail) break;
      end
    endfunction

    // Applies one accepted input word to the predicted state.
    function void note_word(goga_pkg::in_word_t w);
      int i;
      logic signed [7:0] s;
      case (w.command)
        goga_pkg::CMD_CLEAR: foreach (hit_ok[j]) hit_ok[j] = 1'b0;
        goga_pkg::CMD_LOAD: begin
          i = int'(w.hit_y) * TABLE_LEN + int'(w.hit_x);
          s = w.hit_is_ap ? ap_sc : hom_sc;
          if (!hit_ok[i] || s > hit_sc[i]) hit_sc[i] = s;
          hit_ok[i] = 1'b1;
        end
        goga_pkg::CMD_ALIGN: begin
          aligns++;
          predict_align();
        end
        default: ;
      endcase
    endfunction

    task cmp(string name, longint got, longint want);
      if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Compares one accepted result with the oldest expectation.
    task check(goga_pkg::out_word_t got);
      goga_pkg::out_word_t want;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result word %h", got));
        return;
      end
      want = pending.pop_front();
      cmp("pos_x", got.pos_x, want.pos_x);
      cmp("pos_y", got.pos_y, want.pos_y);
      cmp("gaps_x_count", got.gaps_x_count, want.gaps_x_count);
      cmp("gaps_x_at", got.gaps_x_at, want.gaps_x_at);
      cmp("gaps_y_count", got.gaps_y_count, want.gaps_y_count);
      cmp("gaps_y_at", got.gaps_y_at, want.gaps_y_at);
      cmp("too_many_gaps", got.too_many_gaps, want.too_many_gaps);
      cmp("no_hits", got.no_hits, want.no_hits);
      cmp("final_score", got.final_score, want.final_score);
      cmp("last", got.last, want.last);
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  goga_pkg::in_word_t              in_word = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  goga_pkg::out_word_t             out_word;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [goga_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [goga_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  align_scoreboard sb = new();
  bit  calm = 1'b0;
  bit  held_once = 1'b0;
  int  cycles = 0;
  int  words_sent = 0;

  gene_order_global_aligner_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Guard against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("gene_order_global_aligner_unit regression: fail");
      $finish;
    end
  end

  // Result side: random stalls, and one long hold-off after the first result
  // while the sender still has words queued behind the alignment.
  initial begin
    int k;
    @(posedge clk iff rst_n);
    forever begin
      if (!held_once && sb.checked == 1) begin
        held_once = 1'b1;
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
      end
      k = calm ? 0 : $urandom_range(0, 7);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check(out_word);
    end
  end

  // Offers one word after a random gap and waits for it to be taken.
  task automatic send_word(logic [1:0] cmd, int x, int y, bit ap);
    goga_pkg::in_word_t w;
    int gap_cyc;
    w.command = cmd; w.hit_x = x[5:0]; w.hit_y = y[5:0]; w.hit_is_ap = ap;
    gap_cyc = calm ? 0 : $urandom_range(0, 7);
    if (gap_cyc > 0) begin
      in_valid <= 1'b0;
      repeat (gap_cyc) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
    words_sent++;
  endtask

  // Waits for every expected result and for any trailing clear to finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Register write over the configuration port, only while idle; the
  // caller drops the valid after the last write of a burst.
  task automatic write_reg(logic [goga_pkg::CFG_IDX_W-1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[7:0];
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val[7:0]);
  endtask

  task automatic write_all(int g, int mm, int ap, int hm, int mg, int lx, int ly);
    write_reg(goga_pkg::REG_GAP_SCORE, g);
    write_reg(goga_pkg::REG_MISMATCH_SCORE, mm);
    write_reg(goga_pkg::REG_AP_SCORE, ap);
    write_reg(goga_pkg::REG_HOM_SCORE, hm);
    write_reg(goga_pkg::REG_MAX_GAPS, mg);
    write_reg(goga_pkg::REG_LEN_X, lx);
    write_reg(goga_pkg::REG_LEN_Y, ly);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_score();
    case ($urandom_range(0, 5))
      0: return -128;
      1: return 127;
      2: return -int'($urandom_range(1, 12));
      default: return $urandom_range(0, 255) - 128;
    endcase
  endfunction

  function automatic int pick_len();
    case ($urandom_range(0, 15))
      0: return 64;
      1: return 1;
      2: return $urandom_range(65, 127);
      default: return $urandom_range(2, 10);
    endcase
  endfunction

  // Stimulus.
  initial begin
    int ph, n, lx, ly, r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings over the full table.
    send_word(goga_pkg::CMD_CLEAR, 0, 0, 0);
    send_word(goga_pkg::CMD_LOAD, 0, 0, 1);
    send_word(goga_pkg::CMD_LOAD, 63, 63, 0);
    send_word(goga_pkg::CMD_LOAD, 5, 5, 0);
    send_word(goga_pkg::CMD_LOAD, 5, 5, 1);
    send_word(goga_pkg::CMD_LOAD, 10, 14, 1);
    send_word(goga_pkg::CMD_LOAD, 40, 30, 0);
    send_word(CMD_UNUSED, 63, 0, 1);
    send_word(goga_pkg::CMD_ALIGN, 0, 0, 0);
    // These words queue behind the result words during the long hold-off.
    send_word(goga_pkg::CMD_LOAD, 7, 9, 0);
    send_word(CMD_UNUSED, 1, 2, 0);
    settle();

    // Directed: small table, tight gap limit, extreme scores.
    write_all(-128, 127, 127, -128, 0, 8, 6);
    send_word(goga_pkg::CMD_CLEAR, 0, 0, 0);
    send_word(goga_pkg::CMD_LOAD, 1, 0, 1);
    send_word(goga_pkg::CMD_LOAD, 3, 4, 0);
    send_word(goga_pkg::CMD_LOAD, 7, 5, 1);
    send_word(goga_pkg::CMD_LOAD, 20, 2, 1);
    send_word(goga_pkg::CMD_ALIGN, 0, 0, 0);
    settle();
    // Stored scores stay as loaded when the score registers change.
    write_all(-1, -128, -128, 127, 127, 8, 6);
    send_word(goga_pkg::CMD_LOAD, 2, 2, 0);
    send_word(goga_pkg::CMD_ALIGN, 0, 0, 0);
    settle();
    // Empty and oversized lengths.
    write_all(-2, 0, 10, 5, 3, 0, 5);
    send_word(goga_pkg::CMD_ALIGN, 0, 0, 0);
    settle();
    write_all(-2, 0, 10, 5, 3, 127, 3);
    send_word(goga_pkg::CMD_LOAD, 60, 1, 1);
    send_word(goga_pkg::CMD_ALIGN, 0, 0, 0);
    settle();

    // Random phases: fresh settings, mostly hits inside the used area.
    for (ph = 0; ph < 7; ph++) begin
      calm = (ph % 3 == 1);
      lx = pick_len(); ly = pick_len();
      write_all(pick_score(), pick_score(), pick_score(), pick_score(),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                            : $urandom_range(0, 4),
                lx, ly);
      lx = lx > 64 ? 64 : lx; ly = ly > 64 ? 64 : ly;
      if ($urandom_range(0, 1)) send_word(goga_pkg::CMD_CLEAR, $urandom_range(0, 63),
                                          $urandom_range(0, 63), $urandom_range(0, 1));
      n = $urandom_range(12, 18);
      repeat (n) begin
        r = $urandom_range(0, 19);
        if (r < 15)
          send_word(goga_pkg::CMD_LOAD, $urandom_range(0, lx - 1),
                    $urandom_range(0, ly - 1), $urandom_range(0, 1));
        else if (r < 17)
          send_word(goga_pkg::CMD_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 1));
        else if (r < 18)
          send_word(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 1));
        else
          send_word(goga_pkg::CMD_ALIGN, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 1));
      end
      send_word(goga_pkg::CMD_ALIGN, 0, 0, 0);
      settle();
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d input words, %0d alignments, %0d result words checked.",
             words_sent, sb.aligns, sb.checked);
    $display("Mismatches counted: %0d.", sb.errors);
    if (sb.errors == 0)
      $display("gene_order_global_aligner_unit regression: pass");
    else
      $display("gene_order_global_aligner_unit regression: fail");
    $finish;
  end
endmodule
